### design/ctg_pkg.sv
// shared types, constants and saturating helpers for the cubic trajectory generator
`default_nettype none

package ctg_pkg;

    localparam int unsigned FieldW   = 32;
    localparam int unsigned WideW    = 64;
    localparam int unsigned PeriodW  = 16;
    localparam logic [PeriodW-1:0] PeriodReset = 16'd66;

    localparam logic signed [WideW-1:0] WideMax = {1'b0, {(WideW-1){1'b1}}};
    localparam logic signed [WideW-1:0] WideMin = {1'b1, {(WideW-1){1'b0}}};

    typedef logic signed [WideW-1:0]  t_wide;
    typedef logic signed [FieldW-1:0] t_field;

    // right shift applied after a product, or left shift of the dividend before a quotient
    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_16 = 2'd1,
        SH_32 = 2'd2,
        SH_48 = 2'd3
    } t_shift;

    function automatic logic [WideW-1:0] mag(input t_wide v);
        return v[WideW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic t_wide signed_sat(input logic [WideW-1:0] m, input logic neg);
        t_wide r;
        if (neg) begin
            r = m[WideW-1] ? WideMin : t_wide'(~m + 1'b1);
        end else begin
            r = m[WideW-1] ? WideMax : t_wide'(m);
        end
        return r;
    endfunction

    function automatic t_wide sat_add(input t_wide a, input t_wide b);
        logic signed [WideW:0] s;
        t_wide r;
        s = {a[WideW-1], a} + {b[WideW-1], b};
        if (s[WideW] != s[WideW-1]) begin
            r = s[WideW] ? WideMin : WideMax;
        end else begin
            r = s[WideW-1:0];
        end
        return r;
    endfunction

    function automatic t_field clamp32(input t_wide v);
        t_field r;
        if (!v[WideW-1] && (v[WideW-2:FieldW-1] != '0)) begin
            r = {1'b0, {(FieldW-1){1'b1}}};
        end else if (v[WideW-1] && (v[WideW-2:FieldW-1] != '1)) begin
            r = {1'b1, {(FieldW-1){1'b0}}};
        end else begin
            r = v[FieldW-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/cubic_trajectory_generator.sv
// top level: cubic trajectory generator with a shared 32x32 multiplier and a radix-2 divider
// One transaction in gives one transaction out. Each tick is handled alone: the block drops
// s_axis tready from acceptance until its result is loaded into the output register. A tick
// that evaluates the cubic passes through the accept, prepare and check steps, nine 64x64
// products (each a load step, four passes of the shared 32x32 multiplier and a finish step),
// then the round-off and output steps; a tick that latches a new segment first runs the
// squared duration and five bit-serial divisions of a load step, 128 steps and a finish step
// each; a tick past the end of the segment or with a bad duration goes from the check step
// straight to output. The output register lets the next tick be accepted while a result waits
// for m_axis tready.
`default_nettype none

module cubic_trajectory_generator (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [15:0]  i_cfg_wr_data,   // tick_period
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // start_pose, target_pose, start_velocity, target_velocity, start_time, end_time
    input  wire logic [191:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [63:0]       o_m_axis_tdata,  // pose_out, velocity_out
    output logic [2:0]        o_m_axis_tuser   // moving, restarted, bad_duration
);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_DT2, S_LOAD, S_DIV, S_DFIN, S_MUL, S_MFIN, S_EVAL, S_DONE, S_OUT
    } t_state;

    localparam logic [3:0] OP_DT2 = 4'd0;
    localparam logic [3:0] OP_Q1  = 4'd1;
    localparam logic [3:0] OP_Q2  = 4'd2;
    localparam logic [3:0] OP_X   = 4'd3;
    localparam logic [3:0] OP_Q3  = 4'd4;
    localparam logic [3:0] OP_Q4  = 4'd5;
    localparam logic [3:0] OP_T2  = 4'd6;
    localparam logic [3:0] OP_T3  = 4'd7;
    localparam logic [3:0] OP_P1  = 4'd8;
    localparam logic [3:0] OP_P2  = 4'd9;
    localparam logic [3:0] OP_P3  = 4'd10;
    localparam logic [3:0] OP_V1A = 4'd11;
    localparam logic [3:0] OP_V1B = 4'd12;
    localparam logic [3:0] OP_V2A = 4'd13;
    localparam logic [3:0] OP_V2B = 4'd14;

    t_state r_state;
    logic [3:0] r_op;
    logic [15:0] r_period;

    logic [31:0] r_sp, r_tp, r_sv, r_tv, r_st, r_et;
    logic [31:0] r_elapsed, r_lst, r_let, r_ltp, r_ltv;
    ctg_pkg::t_field r_c0, r_c1, r_held_pose, r_held_vel;
    ctg_pkg::t_wide  r_c2, r_c3, r_tmp, r_t, r_t2, r_t3, r_p, r_v, r_m;
    logic [63:0] r_dt2;
    logic r_restarted, r_bad;

    // divider
    logic [127:0] r_dvd;
    logic [63:0]  r_rem, r_q, r_den;
    logic         r_over, r_dneg, r_dnz;
    logic [6:0]   r_cnt;

    // multiplier
    logic [63:0]  r_ma, r_mb;
    logic         r_mneg;
    ctg_pkg::t_shift r_msh;
    logic [1:0]   r_pp;
    logic [127:0] r_acc;

    // pending result
    ctg_pkg::t_field r_res_pose, r_res_vel;
    logic r_res_moving;

    logic [31:0] in_sp, in_tp, in_sv, in_tv, in_st, in_et;
    assign in_sp = i_s_axis_tdata[31:0];
    assign in_tp = i_s_axis_tdata[63:32];
    assign in_sv = i_s_axis_tdata[95:64];
    assign in_tv = i_s_axis_tdata[127:96];
    assign in_st = i_s_axis_tdata[159:128];
    assign in_et = i_s_axis_tdata[191:160];

    assign o_s_axis_tready = (r_state == S_IDLE);

    // restart and elapsed bookkeeping
    logic        chg, do_latch;
    logic [31:0] el0;
    logic [32:0] el_sum;
    assign chg      = (r_tp != r_ltp) || (r_tv != r_ltv) || (r_et != r_let);
    assign el0      = chg ? 32'd0 : r_elapsed;
    assign do_latch = (el0 == 32'd0);
    assign el_sum   = {1'b0, el0} + {17'd0, r_period};

    logic [31:0] dt;
    assign dt = r_et - r_st;

    // shared 32x32 multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    always_comb begin
        if (r_state == S_DT2) begin
            mul_a = dt;
            mul_b = dt;
        end else begin
            mul_a = r_pp[0] ? r_ma[63:32] : r_ma[31:0];
            mul_b = r_pp[1] ? r_mb[63:32] : r_mb[31:0];
        end
    end
    assign prod = mul_a * mul_b;

    logic [127:0] pp_ext;
    always_comb begin
        case ({1'b0, r_pp[0]} + {1'b0, r_pp[1]})
            2'd0:    pp_ext = {64'd0, prod};
            2'd1:    pp_ext = {32'd0, prod, 32'd0};
            default: pp_ext = {prod, 64'd0};
        endcase
    end

    logic [127:0] acc_sh;
    ctg_pkg::t_wide mul_res;
    always_comb begin
        case (r_msh)
            ctg_pkg::SH_16: acc_sh = r_acc >> 16;
            ctg_pkg::SH_32: acc_sh = r_acc >> 32;
            ctg_pkg::SH_48: acc_sh = r_acc >> 48;
            default:        acc_sh = r_acc;
        endcase
        if (acc_sh[127:64] != '0) begin
            mul_res = r_mneg ? ctg_pkg::WideMin : ctg_pkg::WideMax;
        end else begin
            mul_res = ctg_pkg::signed_sat(acc_sh[63:0], r_mneg);
        end
    end

    // divider step
    logic [64:0] rem2, rem_diff;
    logic        rem_ge;
    assign rem2     = {r_rem, r_dvd[127]};
    assign rem_diff = rem2 - {1'b0, r_den};
    assign rem_ge   = (rem2 >= {1'b0, r_den});

    ctg_pkg::t_wide div_res;
    always_comb begin
        if (r_den == '0) begin
            div_res = r_dneg ? ctg_pkg::WideMin : (r_dnz ? ctg_pkg::WideMax : '0);
        end else if (r_over) begin
            div_res = r_dneg ? ctg_pkg::WideMin : ctg_pkg::WideMax;
        end else begin
            div_res = ctg_pkg::signed_sat(r_q, r_dneg);
        end
    end

    // operand selection
    ctg_pkg::t_wide dp, v0, v1, p0;
    assign p0 = {{32{r_sp[31]}}, r_sp};
    assign v0 = {{32{r_sv[31]}}, r_sv};
    assign v1 = {{32{r_tv[31]}}, r_tv};
    assign dp = {{32{r_tp[31]}}, r_tp} - p0;

    ctg_pkg::t_wide  op_a, op_b;
    ctg_pkg::t_shift op_sh;
    logic [63:0]     op_den;
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_sh  = ctg_pkg::SH_0;
        op_den = r_dt2;
        case (r_op)
            OP_Q1:  begin op_a = dp + (dp <<< 1); op_sh = ctg_pkg::SH_48; end
            OP_Q2:  begin
                op_a = -((v0 <<< 1) + v1); op_sh = ctg_pkg::SH_32; op_den = {32'd0, dt};
            end
            OP_X:   begin op_a = -(dp <<< 1); op_sh = ctg_pkg::SH_48; end
            OP_Q3:  begin op_a = r_tmp; op_sh = ctg_pkg::SH_16; op_den = {32'd0, dt}; end
            OP_Q4:  begin op_a = v0 + v1; op_sh = ctg_pkg::SH_48; end
            OP_T2:  begin op_a = r_t;  op_b = r_t;  op_sh = ctg_pkg::SH_16; end
            OP_T3:  begin op_a = r_t2; op_b = r_t;  op_sh = ctg_pkg::SH_16; end
            OP_P1:  begin op_a = {{32{r_c1[31]}}, r_c1}; op_b = r_t; op_sh = ctg_pkg::SH_16; end
            OP_P2:  begin op_a = r_c2; op_b = r_t2; op_sh = ctg_pkg::SH_32; end
            OP_P3:  begin op_a = r_c3; op_b = r_t3; op_sh = ctg_pkg::SH_32; end
            OP_V1A: begin op_a = r_c2; op_b = r_t;  op_sh = ctg_pkg::SH_32; end
            OP_V1B: begin op_a = r_m;  op_b = 64'sd2; end
            OP_V2A: begin op_a = r_c3; op_b = r_t2; op_sh = ctg_pkg::SH_32; end
            OP_V2B: begin op_a = r_m;  op_b = 64'sd3; end
            default: begin op_a = '0; end
        endcase
    end

    logic [63:0] op_amag;
    assign op_amag = ctg_pkg::mag(op_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_op            <= OP_DT2;
            r_period        <= ctg_pkg::PeriodReset;
            r_elapsed       <= '0;
            r_lst           <= '0;
            r_let           <= '0;
            r_ltp           <= '0;
            r_ltv           <= '0;
            r_c0            <= '0;
            r_c1            <= '0;
            r_c2            <= '0;
            r_c3            <= '0;
            r_held_pose     <= '0;
            r_held_vel      <= '0;
            o_m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
            // in S_OUT the output register is reloaded instead
            if (o_m_axis_tvalid && i_m_axis_tready && (r_state != S_OUT)) begin
                o_m_axis_tvalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_sp <= in_sp;
                        r_tp <= in_tp;
                        r_sv <= in_sv;
                        r_tv <= in_tv;
                        r_st <= in_st;
                        r_et <= in_et;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_restarted <= chg;
                    r_elapsed   <= el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
                    if (chg || do_latch) begin
                        r_ltp <= r_tp;
                        r_ltv <= r_tv;
                        r_let <= r_et;
                    end
                    r_state <= S_EVAL;
                    if (do_latch) begin
                        r_lst <= r_st;
                        if (r_et > r_st) begin
                            r_c0    <= r_sp;
                            r_c1    <= r_sv;
                            r_op    <= OP_DT2;
                            r_state <= S_DT2;
                        end else begin
                            r_c0 <= '0;
                            r_c1 <= '0;
                            r_c2 <= '0;
                            r_c3 <= '0;
                        end
                    end
                end
                S_DT2: begin
                    r_dt2   <= prod;
                    r_op    <= OP_Q1;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (r_op <= OP_Q4) begin
                        case (op_sh)
                            ctg_pkg::SH_16: r_dvd <= {64'd0, op_amag} << 16;
                            ctg_pkg::SH_32: r_dvd <= {64'd0, op_amag} << 32;
                            ctg_pkg::SH_48: r_dvd <= {64'd0, op_amag} << 48;
                            default:        r_dvd <= {64'd0, op_amag};
                        endcase
                        r_den   <= op_den;
                        r_dneg  <= op_a[63];
                        r_dnz   <= (op_a != '0);
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_over  <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_ma    <= op_amag;
                        r_mb    <= ctg_pkg::mag(op_b);
                        r_mneg  <= op_a[63] ^ op_b[63];
                        r_msh   <= op_sh;
                        r_acc   <= '0;
                        r_pp    <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_DIV: begin
                    r_dvd <= r_dvd << 1;
                    r_rem <= rem_ge ? rem_diff[63:0] : rem2[63:0];
                    r_q   <= {r_q[62:0], rem_ge};
                    if (r_q[63]) begin
                        r_over <= 1'b1;
                    end
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) begin
                        r_state <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    case (r_op)
                        OP_Q2:   r_c2  <= ctg_pkg::sat_add(r_tmp, div_res);
                        OP_Q4:   r_c3  <= ctg_pkg::sat_add(r_tmp, div_res);
                        default: r_tmp <= div_res;
                    endcase
                    if (r_op == OP_Q4) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_op    <= r_op + 4'd1;
                        r_state <= S_LOAD;
                    end
                end
                S_MUL: begin
                    r_acc <= r_acc + pp_ext;
                    r_pp  <= r_pp + 2'd1;
                    if (r_pp == 2'd3) begin
                        r_state <= S_MFIN;
                    end
                end
                S_MFIN: begin
                    case (r_op)
                        OP_T2:  r_t2 <= mul_res;
                        OP_T3:  r_t3 <= mul_res;
                        OP_P1:  r_p  <= ctg_pkg::sat_add({{32{r_c0[31]}}, r_c0}, mul_res);
                        OP_P2:  r_p  <= ctg_pkg::sat_add(r_p, mul_res);
                        OP_P3:  r_p  <= ctg_pkg::sat_add(r_p, mul_res);
                        OP_V1B: r_v  <= ctg_pkg::sat_add({{32{r_c1[31]}}, r_c1}, mul_res);
                        OP_V2B: r_v  <= ctg_pkg::sat_add(r_v, mul_res);
                        default: r_m <= mul_res;
                    endcase
                    if (r_op == OP_V2B) begin
                        r_state <= S_DONE;
                    end else begin
                        r_op    <= r_op + 4'd1;
                        r_state <= S_LOAD;
                    end
                end
                S_EVAL: begin
                    r_bad <= (r_let <= r_lst);
                    if ((r_let > r_lst) && (r_elapsed <= r_let)) begin
                        r_t     <= {32'd0, r_elapsed} - {32'd0, r_lst};
                        r_op    <= OP_T2;
                        r_state <= S_LOAD;
                    end else begin
                        r_res_pose   <= r_held_pose;
                        r_res_vel    <= r_held_vel;
                        r_res_moving <= 1'b0;
                        r_state      <= S_OUT;
                    end
                end
                S_DONE: begin
                    r_res_pose   <= ctg_pkg::clamp32(r_p);
                    r_res_vel    <= ctg_pkg::clamp32(r_v);
                    r_held_pose  <= ctg_pkg::clamp32(r_p);
                    r_held_vel   <= ctg_pkg::clamp32(r_v);
                    r_res_moving <= 1'b1;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    // wait for the output register to drain
                    if (!o_m_axis_tvalid || i_m_axis_tready) begin
                        o_m_axis_tvalid <= 1'b1;
                        o_m_axis_tdata  <= {r_res_vel, r_res_pose};
                        o_m_axis_tuser  <= {r_bad, r_restarted, r_res_moving};
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
